[rtl/rpfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpfs_pkg: types and helpers for the reference peak finder and shift
// Word layouts, result codes, store sizing and the peak judging rule.
// ----------------------------------------------------------------------------
package rpfs_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_SHIFT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_RANGE   = 2'd1,
		STATUS_DROPPED = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] point_position;
		logic signed [31:0] point_intensity;
		logic               last_point;
		logic [9:0]         read_index;
	} item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] shifted_position;
		logic signed [31:0] read_intensity;
		logic signed [31:0] shift_amount;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] inten;
	} peak_t;

	// candidate: above baseline, not below a present neighbor
	function automatic peak_t judge(
		input logic signed [31:0] pos,
		input logic signed [31:0] inten,
		input logic signed [31:0] base,
		input logic               has_left,
		input logic signed [31:0] left,
		input logic               has_right,
		input logic signed [31:0] right,
		input peak_t              pk
	);
		peak_t r;
		logic  cand;
		r    = pk;
		cand = (inten > base) && !(has_left && (inten < left))
			&& !(has_right && (inten < right));
		if (cand && ((pos > pk.pos) || (inten > pk.inten)) && (pos >= pk.pos)) begin
			r.pos   = pos;
			r.inten = inten;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/reference_peak_finder_and_shift.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reference_peak_finder_and_shift
// Stores pushed spectrum points, tracks the reference peak, reports the
// shift on the last push and returns shifted points on reads.
// ----------------------------------------------------------------------------
//  channel   handshake             word
//  item      item_valid/item_stall item_t: push or read request
//  result    result_valid/stall    result_t: shift report or read data
//  cfg       cfg_valid/cfg_ready   baseline_level, 32 bit signed
//
//  A read passes through the registered store read followed by the saturating
//  subtract, and waits in the read state while the result register is held.
//  No clearing pass: store data is only returned for indexes below the loaded count.
//  Items stall while a read is in flight or the result register is held.
//  Reset clears all control and peak state; the stores keep their contents.
// ----------------------------------------------------------------------------
module reference_peak_finder_and_shift
	import rpfs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic signed [31:0] pos_mem [MAX_POINTS];
	logic signed [31:0] int_mem [MAX_POINTS];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   loaded_count_q;
	logic signed [31:0] prev_pos_q, prev_int_q, bprev_int_q;
	peak_t              peak_q;
	logic signed [31:0] applied_shift_q;
	logic signed [31:0] baseline_q;
	logic               overflow_q, closed_q;

	logic signed [31:0] rd_pos_s1, rd_int_s1;
	logic               rd_oob_s1;

	logic               out_valid_q;
	result_t            out_word_q, out_next;
	logic               out_free, out_load;

	logic               accept, push_acc, read_acc, has_room, ovf_new;
	logic [CNT_W-1:0]   n_eff;
	peak_t              pk1, pk2;
	logic signed [32:0] diff;
	logic signed [31:0] sat_pos;

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_word_q;

	assign out_free = !out_valid_q || !result_stall;
	assign accept   = item_valid && !item_stall;
	assign push_acc = accept && (item.operation == OP_PUSH);
	assign read_acc = accept && (item.operation == OP_READ);

	assign n_eff    = closed_q ? '0 : loaded_count_q;
	assign has_room = n_eff < CNT_W'(MAX_POINTS);
	assign ovf_new  = (!closed_q && overflow_q) || !has_room;

	always_comb begin
		pk1 = peak_q;
		pk2 = peak_q;
		if (has_room) begin
			if (n_eff == '0) begin
				pk1.pos   = item.point_position;
				pk1.inten = item.point_intensity;
			end else begin
				pk1 = judge(prev_pos_q, prev_int_q, baseline_q, n_eff >= CNT_W'(2),
					bprev_int_q, 1'b1, item.point_intensity, peak_q);
			end
			pk2 = pk1;
			if (item.last_point) begin
				pk2 = judge(item.point_position, item.point_intensity, baseline_q,
					n_eff != '0, prev_int_q, 1'b0, '0, pk1);
			end
		end else if (item.last_point) begin
			pk2 = judge(prev_pos_q, prev_int_q, baseline_q, 1'b1, bprev_int_q,
				1'b0, '0, peak_q);
		end
	end

	// saturating subtract of the shift
	assign diff = {rd_pos_s1[31], rd_pos_s1} - {applied_shift_q[31], applied_shift_q};
	always_comb begin
		if (diff[32] != diff[31]) begin
			sat_pos = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_pos = diff[31:0];
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b0;
		out_load   = 1'b0;
		out_next   = '0;
		case (state_q)
			ST_IDLE: begin
				item_stall = !out_free;
				if (read_acc) begin
					state_d = ST_READ;
				end
				if (push_acc && item.last_point) begin
					out_load              = 1'b1;
					out_next.result_kind  = KIND_SHIFT;
					out_next.shift_amount = pk2.pos;
					out_next.status       = ovf_new ? STATUS_DROPPED : STATUS_OK;
				end
			end
			ST_READ: begin
				item_stall           = 1'b1;
				out_next.result_kind = KIND_READ;
				if (rd_oob_s1) begin
					out_next.status = STATUS_RANGE;
				end else begin
					out_next.shifted_position = sat_pos;
					out_next.read_intensity   = rd_int_s1;
					out_next.shift_amount     = applied_shift_q;
					out_next.status           = STATUS_OK;
				end
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc && has_room) begin
			pos_mem[n_eff[ADDR_W-1:0]] <= item.point_position;
			int_mem[n_eff[ADDR_W-1:0]] <= item.point_intensity;
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc) begin
			rd_pos_s1 <= pos_mem[ADDR_W'(item.read_index)];
			rd_int_s1 <= int_mem[ADDR_W'(item.read_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_s1 <= 1'b0;
		end else if (read_acc) begin
			rd_oob_s1 <= 32'(item.read_index) >= 32'(loaded_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			baseline_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q  <= '0;
			prev_pos_q      <= '0;
			prev_int_q      <= '0;
			bprev_int_q     <= '0;
			peak_q          <= '0;
			applied_shift_q <= '0;
			overflow_q      <= 1'b0;
			closed_q        <= 1'b0;
		end else if (push_acc) begin
			peak_q          <= pk2;
			overflow_q      <= ovf_new;
			closed_q        <= item.last_point;
			applied_shift_q <= item.last_point ? pk2.pos : '0;
			if (has_room) begin
				loaded_count_q <= n_eff + CNT_W'(1);
				prev_pos_q     <= item.point_position;
				prev_int_q     <= item.point_intensity;
				bprev_int_q    <= prev_int_q;
			end else begin
				loaded_count_q <= n_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= out_next;
		end
	end

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> item_stall)
		else $error("item taken during read");

	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |=> state_q == ST_READ)
		else $error("read not started");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_count_q <= CNT_W'(MAX_POINTS))
		else $error("loaded count over capacity");

	a_shift_closed: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> applied_shift_q == peak_q.pos)
		else $error("shift differs from peak");

	a_shift_open: assert property (@(posedge clk) disable iff (!arst_n)
		!closed_q |-> applied_shift_q == '0)
		else $error("shift set on open spectrum");

endmodule
`default_nettype wire

[test/tb_reference_peak_finder_and_shift.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_reference_peak_finder_and_shift: self-checking bench for the peak finder
// A short table of pushes and reads with hand-typed answers where obvious,
// then random spectra under several baseline settings, one of them past the
// store capacity. The other result words are checked against a local predictor of
// the peak search and the saturating shift, with random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_reference_peak_finder_and_shift;
	import rpfs_pkg::*;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct {
		item_t   word;
		bit      has_fixed;
		result_t fixed;
	} seed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic signed [31:0] stored_pos [MAX_POINTS];
	logic signed [31:0] stored_int [MAX_POINTS];
	logic [CNT_W-1:0]   n_stored = '0;
	logic signed [31:0] last_pos = '0;
	logic signed [31:0] last_int = '0;
	logic signed [31:0] older_int = '0;
	logic signed [31:0] best_pos = '0;
	logic signed [31:0] best_int = '0;
	logic signed [31:0] shift_now = '0;
	logic signed [31:0] base_now = '0;
	bit                 lost_point = 1'b0;
	bit                 spectrum_done = 1'b0;

	result_t     expected_results [$];
	result_t     oldest;
	seed_row_t   seed_rows [25];
	int          mismatches = 0;
	int          words_sent = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	int          stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;

	reference_peak_finder_and_shift uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void consider_peak(input logic signed [31:0] p, v,
			input bit has_l, input logic signed [31:0] l,
			input bit has_r, input logic signed [31:0] rt);
		if (v <= base_now)
			return;
		if (has_l && v < l)
			return;
		if (has_r && v < rt)
			return;
		if ((p > best_pos || v > best_int) && p >= best_pos) begin
			best_pos = p;
			best_int = v;
		end
	endfunction

	function automatic logic signed [31:0] minus_sat(input logic signed [31:0] a, b);
		logic signed [32:0] d;
		d = a - b;
		if (d[32] != d[31])
			return d[32] ? S32_MIN : S32_MAX;
		return d[31:0];
	endfunction

	// returns 1 when the word produces a result
	function automatic bit predict_result(input item_t it, output result_t r);
		logic [CNT_W-1:0] n;
		r = '0;
		if (it.operation == OP_READ) begin
			r.result_kind = KIND_READ;
			if (it.read_index >= n_stored) begin
				r.status = STATUS_RANGE;
			end else begin
				r.shifted_position = minus_sat(stored_pos[it.read_index], shift_now);
				r.read_intensity   = stored_int[it.read_index];
				r.shift_amount     = shift_now;
				r.status           = STATUS_OK;
			end
			return 1'b1;
		end
		if (spectrum_done) begin
			n_stored      = '0;
			lost_point    = 1'b0;
			shift_now     = '0;
			spectrum_done = 1'b0;
		end
		n = n_stored;
		if (n < MAX_POINTS) begin
			stored_pos[n[ADDR_W-1:0]] = it.point_position;
			stored_int[n[ADDR_W-1:0]] = it.point_intensity;
			if (n == 0) begin
				best_pos = it.point_position;
				best_int = it.point_intensity;
			end else begin
				consider_peak(last_pos, last_int, n >= 2, older_int, 1'b1, it.point_intensity);
			end
			older_int = last_int;
			last_pos  = it.point_position;
			last_int  = it.point_intensity;
			n_stored  = n + 1'b1;
			if (it.last_point)
				consider_peak(it.point_position, it.point_intensity, n >= 1, older_int,
					1'b0, '0);
		end else begin
			lost_point = 1'b1;
			if (it.last_point)
				consider_peak(last_pos, last_int, n >= 2, older_int, 1'b0, '0);
		end
		if (!it.last_point)
			return 1'b0;
		shift_now     = best_pos;
		spectrum_done = 1'b1;
		r.result_kind  = KIND_SHIFT;
		r.shift_amount = shift_now;
		r.status       = lost_point ? STATUS_DROPPED : STATUS_OK;
		return 1'b1;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.operation       = OP_PUSH;
		it.point_position  = $urandom;
		it.point_intensity = $urandom;
		it.last_point      = 1'b0;
		it.read_index      = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	function automatic item_t push_word(input logic signed [31:0] p, v, input logic last);
		item_t it;
		it                 = random_item();
		it.point_position  = p;
		it.point_intensity = v;
		it.last_point      = last;
		return it;
	endfunction

	function automatic item_t read_word(input logic [9:0] idx);
		item_t it;
		it            = random_item();
		it.operation  = OP_READ;
		it.last_point = 1'($urandom_range(0, 1));
		it.read_index = idx;
		return it;
	endfunction

	function automatic result_t result_word(input logic kind,
			input logic signed [31:0] spos, rint, shamt, input status_t st);
		result_t r;
		r.result_kind      = kind;
		r.shifted_position = spos;
		r.read_intensity   = rint;
		r.shift_amount     = shamt;
		r.status           = st;
		return r;
	endfunction

	function automatic seed_row_t open_row(input item_t it);
		seed_row_t s;
		s.word      = it;
		s.has_fixed = 1'b0;
		s.fixed     = '0;
		return s;
	endfunction

	function automatic seed_row_t fixed_row(input item_t it, input result_t want);
		seed_row_t s;
		s.word      = it;
		s.has_fixed = 1'b1;
		s.fixed     = want;
		return s;
	endfunction

	// mostly valid indexes, some at or past the loaded count
	function automatic logic [9:0] pick_index();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && n_stored != 0)
			return 10'($urandom_range(0, n_stored - 1));
		if (sel == 6 && n_stored < MAX_POINTS)
			return n_stored[9:0];
		if (sel == 7)
			return 10'h3FF;
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
		end
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic pace();
		int gap;
		bit hold;
		gap  = 0;
		hold = ($urandom_range(0, 49) == 0);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 30);
		end
		if (hold || gap != 0) begin
			item_valid <= 1'b0;
			if (hold)
				wait_drained();
			repeat (gap > 0 ? gap : 1) @(posedge clk);
		end
	endtask

	task automatic send(input item_t it, input bit has_fixed, input result_t fixed);
		result_t r;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		words_sent++;
		if (predict_result(it, r))
			expected_results = {expected_results, (has_fixed ? fixed : r)};
		pace();
	endtask

	task automatic send_read(input logic [9:0] idx);
		send(read_word(idx), 1'b0, '0);
	endtask

	task automatic send_spectrum(input int total);
		item_t              it;
		int                 pstyle, istyle, apex, span;
		logic signed [31:0] p;
		pstyle = $urandom_range(0, 3);
		istyle = $urandom_range(0, 3);
		apex   = $urandom_range(0, total - 1);
		p      = $urandom;
		for (int i = 0; i < total; i++) begin
			case (pstyle)
				0: p = p + $urandom_range(0, 3);
				1: p = p - $urandom_range(0, 3);
				2: p = $urandom;
				default: p = $urandom_range(0, 4) - 2;
			endcase
			span = (i > apex) ? i - apex : apex - i;
			case (istyle)
				0: it = push_word(p, base_now + $urandom_range(0, 8) - 4, 1'b0);
				1: it = push_word(p, $urandom, 1'b0);
				2: it = push_word(p, $urandom_range(0, 6) - 3, 1'b0);
				default: it = push_word(p, base_now + (total - span) * 8 + $urandom_range(0, 2),
					1'b0);
			endcase
			it.last_point = (i == total - 1);
			send(it, 1'b0, '0);
			if ($urandom_range(0, 11) == 0)
				send_read(pick_index());
		end
	endtask

	task automatic write_baseline(input logic signed [31:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_now = v;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_SPARSE:   result_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: result_stall <= (stall_tick % 5) < 2;
			default:        result_stall <= ($urandom_range(0, 3) != 0);
		endcase
		if (stall_tick % 256 == 255)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, got %p", $time, result);
			end else begin
				oldest = expected_results.pop_front();
				check_field("result_kind", 32'(oldest.result_kind), 32'(result.result_kind));
				check_field("shifted_position", oldest.shifted_position,
					result.shifted_position);
				check_field("read_intensity", oldest.read_intensity, result.read_intensity);
				check_field("shift_amount", oldest.shift_amount, result.shift_amount);
				check_field("status", 32'(oldest.status), 32'(result.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] base_pick;
		int                 target;

		seed_rows[0]  = fixed_row(read_word(10'd0),
			result_word(KIND_READ, 0, 0, 0, STATUS_RANGE));
		seed_rows[1]  = fixed_row(read_word(10'h3FF),
			result_word(KIND_READ, 0, 0, 0, STATUS_RANGE));
		seed_rows[2]  = open_row(push_word(100, 50, 1'b0));
		seed_rows[3]  = open_row(push_word(200, 300, 1'b0));
		seed_rows[4]  = fixed_row(push_word(300, 100, 1'b1),
			result_word(KIND_SHIFT, 0, 0, 200, STATUS_OK));
		seed_rows[5]  = fixed_row(read_word(10'd0),
			result_word(KIND_READ, -100, 50, 200, STATUS_OK));
		seed_rows[6]  = open_row(read_word(10'd2));
		seed_rows[7]  = fixed_row(read_word(10'd3),
			result_word(KIND_READ, 0, 0, 0, STATUS_RANGE));
		seed_rows[8]  = open_row(push_word(S32_MIN, S32_MAX, 1'b0));
		seed_rows[9]  = open_row(push_word(S32_MAX, S32_MIN, 1'b0));
		seed_rows[10] = open_row(push_word(0, 0, 1'b1));
		seed_rows[11] = open_row(read_word(10'd1));
		seed_rows[12] = open_row(read_word(10'd0));
		seed_rows[13] = open_row(push_word(S32_MIN, 1, 1'b0));
		seed_rows[14] = open_row(push_word(1000, 10, 1'b1));
		seed_rows[15] = open_row(read_word(10'd0));
		seed_rows[16] = fixed_row(push_word(-5, -7, 1'b1),
			result_word(KIND_SHIFT, 0, 0, -5, STATUS_OK));
		seed_rows[17] = fixed_row(read_word(10'd0),
			result_word(KIND_READ, 0, -7, -5, STATUS_OK));
		seed_rows[18] = fixed_row(read_word(10'd1),
			result_word(KIND_READ, 0, 0, 0, STATUS_RANGE));
		// flat top, then a higher peak at a lower position
		seed_rows[19] = open_row(push_word(10, 5, 1'b0));
		seed_rows[20] = open_row(push_word(20, 5, 1'b0));
		seed_rows[21] = open_row(push_word(30, 5, 1'b1));
		seed_rows[22] = open_row(push_word(50, 1, 1'b0));
		seed_rows[23] = open_row(push_word(40, 9, 1'b0));
		seed_rows[24] = open_row(push_word(30, 1, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (seed_rows[i])
			send(seed_rows[i].word, seed_rows[i].has_fixed, seed_rows[i].fixed);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: base_pick = S32_MIN;
				1: base_pick = S32_MAX;
				2: base_pick = $urandom_range(0, 64) - 32;
				3: base_pick = $urandom;
				default: base_pick = -1;
			endcase
			write_baseline(base_pick);
			if (ph == 3) begin
				// fill the store, drop a few, close on a dropped word
				send_spectrum(MAX_POINTS + 3);
				send_read(10'h3FF);
				repeat (4) send_read(pick_index());
			end
			target = words_sent + 150;
			while (words_sent < target) begin
				send_spectrum(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
					: $urandom_range(1, 12));
				repeat ($urandom_range(0, 5)) send_read(pick_index());
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
rtl/rpfs_pkg.sv
rtl/reference_peak_finder_and_shift.sv
test/tb_reference_peak_finder_and_shift.sv
